>>> rtl/afu_pkg.sv
// afu_pkg: shared types, constants and elaboration-time table functions
// for the activation function unit; no dependencies
package afu_pkg;

    localparam int DATA_WIDTH_DEF    = 16;
    localparam int FRAC_BITS_DEF     = 12;
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int GAIN_W            = 13;
    localparam int KIND_W            = 3;
    localparam int APB_AW            = 4;
    localparam int APB_DW            = 32;

    localparam logic [63:0] Q32 = 64'd1 << 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_SIGMOID  = 3'd0,
        KIND_STEP     = 3'd1,
        KIND_LINEAR   = 3'd2,
        KIND_TANH     = 3'd3,
        KIND_RELU     = 3'd4,
        KIND_LEAKY    = 3'd5,
        KIND_IDENTITY = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        REG_KIND   = 2'd0,
        REG_LINEAR = 2'd1,
        REG_LEAK   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_kind             kind;
        logic [GAIN_W-1:0] linear_gain;
        logic [GAIN_W-1:0] leak_gain;
    } t_cfg;

    // unsigned quotient by shift and subtract
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^(-f) in q32 for f in [0, 1/2], series
    function automatic logic [63:0] exp_neg_small(input logic [63:0] f);
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        pos  = Q32;
        neg  = '0;
        term = Q32;
        for (int i = 1; i <= 24; i++) begin
            term = udiv64((term * f) >> 32, 64'(i));
            if (i[0]) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        return pos - neg;
    endfunction

    // e^(-x) in q32 for x >= 0
    function automatic logic [63:0] exp_neg(input logic [63:0] x);
        logic [63:0] half_e;
        logic [63:0] r;
        logic [63:0] n;
        if (x >= (64'd64 << 32)) begin
            return '0;
        end
        half_e = exp_neg_small(Q32 >> 1);
        r      = exp_neg_small(x & ((Q32 >> 1) - 64'd1));
        n      = x >> 31;
        for (logic [63:0] k = '0; k < n; k++) begin
            r = (r * half_e) >> 32;
        end
        return r;
    endfunction

    function automatic logic [63:0] scale_x(input logic [63:0] xq, input int dw,
                                            input int fb);
        int s;
        s = dw - 1 - fb;
        if (s >= 0) begin
            if (xq > ((64'd64 << 32) >> s)) begin
                return 64'd64 << 32;
            end
            return xq << s;
        end
        return xq >> (-s);
    endfunction

    function automatic logic [63:0] sig_entry(input logic [63:0] xq, input int dw,
                                              input int fb);
        logic [63:0] x;
        logic [63:0] e;
        logic [63:0] den;
        x   = scale_x(xq, dw, fb);
        e   = exp_neg(x);
        den = Q32 + e;
        return udiv64((64'd1 << (32 + fb)) + (den >> 1), den);
    endfunction

    function automatic logic [63:0] tanh_entry(input logic [63:0] xq, input int dw,
                                               input int fb);
        logic [63:0] x;
        logic [63:0] e;
        logic [63:0] den;
        x   = scale_x(xq, dw, fb);
        e   = exp_neg(x * 64'd2);
        den = Q32 + e;
        return udiv64(((Q32 - e) << fb) + (den >> 1), den);
    endfunction

endpackage

>>> rtl/afu_rom.sv
// afu_rom: sigmoid and tanh sample tables with two registered read ports
// depends on afu_pkg for the table functions
module afu_rom #(
    parameter int DATA_WIDTH    = afu_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS     = afu_pkg::FRAC_BITS_DEF,
    parameter int TABLE_ENTRIES = afu_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic                                  i_tanh,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]    i_addr_a,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]    i_addr_b,
    output logic [FRAC_BITS:0]                    o_data_a,
    output logic [FRAC_BITS:0]                    o_data_b
);
    import afu_pkg::*;

    localparam int TW = FRAC_BITS + 1;

    logic [TW-1:0] sig_tab  [TABLE_ENTRIES+1];
    logic [TW-1:0] tanh_tab [TABLE_ENTRIES+1];
    logic [TW-1:0] r_data_a;
    logic [TW-1:0] r_data_b;

    for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_tab
        localparam logic [63:0] XQ  = (64'(k) << 32) / TABLE_ENTRIES;
        localparam logic [63:0] SIG = sig_entry(XQ, DATA_WIDTH, FRAC_BITS);
        localparam logic [63:0] TNH = tanh_entry(XQ, DATA_WIDTH, FRAC_BITS);
        assign sig_tab[k]  = SIG[TW-1:0];
        assign tanh_tab[k] = TNH[TW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= i_tanh ? tanh_tab[i_addr_a] : sig_tab[i_addr_a];
            r_data_b <= i_tanh ? tanh_tab[i_addr_b] : sig_tab[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

>>> rtl/afu_pipe.sv
// afu_pipe: four-stage datapath (table read, interpolation, derivative
// product, round and saturate); depends on afu_pkg and afu_rom
module afu_pipe #(
    parameter int DATA_WIDTH    = afu_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS     = afu_pkg::FRAC_BITS_DEF,
    parameter int TABLE_ENTRIES = afu_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  afu_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic signed [DATA_WIDTH-1:0]  i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [DATA_WIDTH-1:0]  o_result
);
    import afu_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int AW  = $clog2(TABLE_ENTRIES + 1);
    localparam int PW  = DW + AW;
    localparam int TW  = F + 1;
    localparam int YW  = F + 2;
    localparam int MW  = F + DW;
    localparam int GW  = GAIN_W + 1;
    localparam int LW  = DW + GW;
    localparam int DPW = 2 * F + 6;
    localparam int WW  = (DW + 16 > DPW) ? DW + 16 : DPW;

    localparam logic [PW-1:0]        TE_P    = PW'(TABLE_ENTRIES);
    localparam logic [AW-1:0]        IDX_END = AW'(TABLE_ENTRIES);
    localparam logic [MW:0]          FR_HALF = {{(MW-DW+2){1'b0}}, 1'b1, {(DW-2){1'b0}}};
    localparam logic [YW-1:0]        ONE_Y   = {2'b01, {F{1'b0}}};
    localparam logic signed [YW:0]   ONE_Y1  = {3'b001, {F{1'b0}}};
    localparam logic signed [WW-1:0] ONE_W   = {{(WW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [WW-1:0] HALF_W  = {{(WW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [WW-1:0] SAT_HI  = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [WW-1:0] SAT_LO  = {{(WW-DW+1){1'b1}}, {(DW-1){1'b0}}};

    logic en1, en2, en3, en4;

    // stage 0
    logic                 neg0;
    logic [DW-1:0]        a0;
    logic [PW-1:0]        p0;
    logic [AW-1:0]        idx0;
    logic                 end0;
    logic [AW-1:0]        addr_b0;
    logic [GAIN_W-1:0]    gain0;
    logic signed [LW-1:0] n1_prod;

    // stage 1
    logic                  r1_v;
    logic                  r1_mode;
    logic                  r1_neg;
    logic                  r1_end;
    logic signed [DW-1:0]  r1_x;
    logic [DW-2:0]         r1_fr;
    logic signed [LW-1:0]  r1_prod;
    logic [TW-1:0]         rom_a;
    logic [TW-1:0]         rom_b;

    // stage 2
    logic signed [YW-1:0]  diff2;
    logic [TW-1:0]         mag2;
    logic [MW-1:0]         ip2;
    logic [MW:0]           is2;
    logic [YW-1:0]         yabs2;
    logic signed [YW-1:0]  n2_y;
    logic signed [WW-1:0]  x2w;
    logic signed [WW-1:0]  rnd2;
    logic signed [WW-1:0]  lin2w;
    logic signed [WW-1:0]  leak2w;
    logic                  pos2;
    logic                  nonneg2;
    logic signed [WW-1:0]  n2_simple;
    logic                  r2_v;
    logic                  r2_mode;
    logic signed [YW-1:0]  r2_y;
    logic signed [WW-1:0]  r2_simple;

    // stage 3
    logic signed [YW:0]    ya3;
    logic signed [YW:0]    yb3;
    logic signed [DPW-1:0] n3_dprod;
    logic                  r3_v;
    logic                  r3_mode;
    logic signed [YW-1:0]  r3_y;
    logic signed [WW-1:0]  r3_simple;
    logic signed [DPW-1:0] r3_dprod;

    // stage 4
    logic signed [WW-1:0]  rq4;
    logic signed [WW-1:0]  full4;
    logic signed [DW-1:0]  n_result;
    logic                  r4_v;
    logic signed [DW-1:0]  r_result;

    assign en4 = !r4_v || i_out_ready;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign o_in_ready = en1;

    // magnitude to table index and fraction
    always_comb begin
        neg0    = i_value[DW-1];
        a0      = neg0 ? DW'(~i_value + 1'b1) : i_value;
        p0      = PW'(a0) * TE_P;
        idx0    = p0[DW-1 +: AW];
        end0    = (idx0 >= IDX_END);
        addr_b0 = end0 ? idx0 : idx0 + 1'b1;
        gain0   = (i_cfg.kind == KIND_LINEAR) ? i_cfg.linear_gain : i_cfg.leak_gain;
        n1_prod = LW'(i_value) * LW'($signed({1'b0, gain0}));
    end

    afu_rom #(
        .DATA_WIDTH    (DATA_WIDTH),
        .FRAC_BITS     (FRAC_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_afu_rom (
        .i_clk    (i_clk),
        .i_en     (en1),
        .i_tanh   (i_cfg.kind == KIND_TANH),
        .i_addr_a (idx0),
        .i_addr_b (addr_b0),
        .o_data_a (rom_a),
        .o_data_b (rom_b)
    );

    // interpolation and the table-free kinds
    always_comb begin
        diff2 = $signed({1'b0, rom_b}) - $signed({1'b0, rom_a});
        mag2  = diff2[YW-1] ? '0 : diff2[TW-1:0];
        ip2   = MW'(mag2) * MW'(r1_fr);
        is2   = (MW+1)'(ip2) + FR_HALF;
        yabs2 = r1_end ? YW'(rom_a) : YW'(rom_a) + is2[DW-1 +: YW];
        if (!r1_neg) begin
            n2_y = $signed(yabs2);
        end else if (i_cfg.kind == KIND_TANH) begin
            n2_y = $signed(YW'(~yabs2 + 1'b1));
        end else begin
            n2_y = $signed(YW'(ONE_Y - yabs2));
        end

        x2w     = WW'(r1_x);
        rnd2    = (WW'(r1_prod) + HALF_W) >>> F;
        lin2w   = $signed(WW'(i_cfg.linear_gain));
        leak2w  = $signed(WW'(i_cfg.leak_gain));
        nonneg2 = !r1_x[DW-1];
        pos2    = nonneg2 && (r1_x != '0);
        case (i_cfg.kind)
            KIND_STEP: begin
                n2_simple = (!r1_mode && pos2) ? ONE_W : '0;
            end
            KIND_LINEAR: begin
                n2_simple = r1_mode ? lin2w : rnd2;
            end
            KIND_RELU: begin
                if (r1_mode) begin
                    n2_simple = nonneg2 ? ONE_W : '0;
                end else begin
                    n2_simple = pos2 ? x2w : '0;
                end
            end
            KIND_LEAKY: begin
                if (r1_mode) begin
                    n2_simple = nonneg2 ? ONE_W : leak2w;
                end else begin
                    n2_simple = nonneg2 ? x2w : rnd2;
                end
            end
            default: begin
                n2_simple = x2w;
            end
        endcase
    end

    // derivative product
    always_comb begin
        ya3      = (YW+1)'(r2_y);
        yb3      = (i_cfg.kind == KIND_TANH) ? ya3 : ONE_Y1 - ya3;
        n3_dprod = DPW'(ya3) * DPW'(yb3);
    end

    // round and saturate
    always_comb begin
        rq4 = (WW'(r3_dprod) + HALF_W) >>> F;
        case (i_cfg.kind)
            KIND_SIGMOID: begin
                full4 = r3_mode ? rq4 : WW'(r3_y);
            end
            KIND_TANH: begin
                full4 = r3_mode ? ONE_W - rq4 : WW'(r3_y);
            end
            default: begin
                full4 = r3_simple;
            end
        endcase
        if (full4 > SAT_HI) begin
            n_result = SAT_HI[DW-1:0];
        end else if (full4 < SAT_LO) begin
            n_result = SAT_LO[DW-1:0];
        end else begin
            n_result = full4[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (en1) begin
                r1_v <= i_in_valid;
            end
            if (en2) begin
                r2_v <= r1_v;
            end
            if (en3) begin
                r3_v <= r2_v;
            end
            if (en4) begin
                r4_v <= r3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_mode <= i_mode;
            r1_neg  <= neg0;
            r1_end  <= end0;
            r1_x    <= i_value;
            r1_fr   <= p0[DW-2:0];
            r1_prod <= n1_prod;
        end
        if (en2) begin
            r2_mode   <= r1_mode;
            r2_y      <= n2_y;
            r2_simple <= n2_simple;
        end
        if (en3) begin
            r3_mode   <= r2_mode;
            r3_y      <= r2_y;
            r3_simple <= r2_simple;
            r3_dprod  <= n3_dprod;
        end
        if (en4) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r4_v;
    assign o_result    = r_result;

endmodule

>>> rtl/activation_function_unit.sv
// activation_function_unit: apb configuration registers and the datapath
// depends on afu_pkg and afu_pipe
// a result is registered through the table read, interpolation, derivative product and round stages
// throughput: one transfer per cycle while the output is not stalled, set by the fully pipelined four-stage datapath
// reset: synchronous active-low; clears pipeline valids, kind to sigmoid,
// gains to 0.25 and about 0.1
module activation_function_unit #(
    parameter int DATA_WIDTH    = afu_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS     = afu_pkg::FRAC_BITS_DEF,
    parameter int TABLE_ENTRIES = afu_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [afu_pkg::APB_AW-1:0]    paddr,
    input  logic [afu_pkg::APB_DW-1:0]    pwdata,
    output logic [afu_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic signed [DATA_WIDTH-1:0]  i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [DATA_WIDTH-1:0]  o_result
);
    import afu_pkg::*;

    localparam logic [GAIN_W-1:0] LIN_RST  = GAIN_W'(64'd1 << (FRAC_BITS - 2));
    localparam logic [GAIN_W-1:0] LEAK_RST =
        GAIN_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    t_kind             r_kind;
    logic [GAIN_W-1:0] r_linear_gain;
    logic [GAIN_W-1:0] r_leak_gain;
    logic              wr_en;
    t_reg_idx          reg_idx;
    t_cfg              cfg;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind        <= KIND_SIGMOID;
            r_linear_gain <= LIN_RST;
            r_leak_gain   <= LEAK_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_KIND: begin
                    r_kind <= t_kind'(pwdata[KIND_W-1:0]);
                end
                REG_LINEAR: begin
                    r_linear_gain <= pwdata[GAIN_W-1:0];
                end
                REG_LEAK: begin
                    r_leak_gain <= pwdata[GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KIND:   prdata = APB_DW'(r_kind);
            REG_LINEAR: prdata = APB_DW'(r_linear_gain);
            REG_LEAK:   prdata = APB_DW'(r_leak_gain);
            default:    prdata = '0;
        endcase
    end

    assign cfg.kind        = r_kind;
    assign cfg.linear_gain = r_linear_gain;
    assign cfg.leak_gain   = r_leak_gain;

    afu_pipe #(
        .DATA_WIDTH    (DATA_WIDTH),
        .FRAC_BITS     (FRAC_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_afu_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

endmodule

>>> rtl/afu_checker.sv
// afu_checker: port-level assertions for activation_function_unit
// bound to the top level below; no package dependency
module afu_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [DATA_WIDTH-1:0]  o_result
);

    // no result right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result))
        else $error("stalled result changed");

    // free output side means input side is open
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input blocked while output side is free");

    // a transfer reaches the output if the receiver stays ready while it moves through the stages
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> o_out_valid)
        else $error("transfer did not reach the output");

endmodule

bind activation_function_unit afu_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_afu_checker (.*);

>>> tb/sv/tb_activation_function_unit.sv
// testbench for activation_function_unit: drives items with random bursts and
// output stalls, predicts each result and compares it on transfer
// depends on afu_pkg and the activation_function_unit rtl
module tb_activation_function_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import afu_pkg::*;

    localparam int DW            = DATA_WIDTH_DEF;
    localparam int FB            = FRAC_BITS_DEF;
    localparam int TE            = TABLE_ENTRIES_DEF;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd7;
    localparam longint ONE_Q     = 64'sd1 << FB;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PRINT_LIMIT   = 50;
    localparam logic [GAIN_W-1:0] LINEAR_DEF = 13'd1024;
    localparam logic [GAIN_W-1:0] LEAK_DEF   = 13'd410;

    typedef struct {
        logic                 mode;
        logic signed [DW-1:0] value;
    } t_stim;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [APB_AW-1:0]    paddr       = '0;
    logic [APB_DW-1:0]    pwdata      = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic                 i_mode      = 1'b0;
    logic signed [DW-1:0] i_value     = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [DW-1:0] o_result;

    logic [KIND_W-1:0]    cur_kind   = KIND_SIGMOID;
    logic [GAIN_W-1:0]    cur_linear = LINEAR_DEF;
    logic [GAIN_W-1:0]    cur_leak   = LEAK_DEF;

    longint               sigmoid_pts [0:TE];
    longint               tanh_pts    [0:TE];

    t_stim                pending_stim[$];
    logic signed [DW-1:0] predicted_outputs[$];
    t_stim                next_stim;
    logic signed [DW-1:0] want;

    int burst_left  = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int stall_mode  = 0;
    int error_count = 0;
    int cycle_count = 0;

    activation_function_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // e^(-f) in q32 for small f, alternating series
    function automatic bit [63:0] exp_series(input bit [63:0] f);
        bit [63:0] plus_sum;
        bit [63:0] minus_sum;
        bit [63:0] term;
        bit [63:0] divisor;
        plus_sum  = Q32;
        minus_sum = '0;
        term      = Q32;
        for (int i = 1; i <= 24; i++) begin
            divisor = 64'(i);
            term    = ((term * f) >> 32) / divisor;
            if (i % 2 == 1) begin
                minus_sum += term;
            end else begin
                plus_sum += term;
            end
        end
        return plus_sum - minus_sum;
    endfunction

    function automatic bit [63:0] exp_decay(input bit [63:0] x);
        bit [63:0] half_step;
        bit [63:0] r;
        bit [63:0] steps;
        if (x >= (64'd64 << 32)) begin
            return '0;
        end
        half_step = exp_series(Q32 >> 1);
        r         = exp_series(x & ((Q32 >> 1) - 64'd1));
        steps     = x >> 31;
        for (bit [63:0] j = 0; j < steps; j++) begin
            r = (r * half_step) >> 32;
        end
        return r;
    endfunction

    function automatic void fill_curves();
        bit [63:0] kk;
        bit [63:0] x;
        bit [63:0] e;
        bit [63:0] den;
        int        s;
        s = DW - 1 - FB;
        for (int k = 0; k <= TE; k++) begin
            kk = 64'(k);
            x  = (kk << 32) / TE;
            if (s >= 0) begin
                if (x > ((64'd64 << 32) >> s)) begin
                    x = 64'd64 << 32;
                end else begin
                    x = x << s;
                end
            end else begin
                x = x >> (-s);
            end
            e   = exp_decay(x);
            den = Q32 + e;
            sigmoid_pts[k] = ((64'd1 << (32 + FB)) + den / 2) / den;
            e   = exp_decay(x * 2);
            den = Q32 + e;
            tanh_pts[k] = (((Q32 - e) << FB) + den / 2) / den;
        end
    endfunction

    // sample points are f at k * 2^(DW-1) / TE, interpolated on |x|
    function automatic longint curve_at(input bit use_tanh, input longint mag);
        longint p;
        longint idx;
        longint fr;
        longint lo;
        longint hi;
        longint diff;
        p   = mag * TE;
        idx = p >>> (DW - 1);
        fr  = p & ((64'sd1 << (DW - 1)) - 1);
        if (idx >= TE) begin
            return use_tanh ? tanh_pts[TE] : sigmoid_pts[TE];
        end
        lo   = use_tanh ? tanh_pts[int'(idx)] : sigmoid_pts[int'(idx)];
        hi   = use_tanh ? tanh_pts[int'(idx) + 1] : sigmoid_pts[int'(idx) + 1];
        diff = hi - lo;
        if (diff < 0) begin
            diff = 0;
        end
        return lo + ((diff * fr + (64'sd1 << (DW - 2))) >>> (DW - 1));
    endfunction

    function automatic longint round_frac(input longint v);
        return (v + (ONE_Q >>> 1)) >>> FB;
    endfunction

    function automatic logic signed [DW-1:0] activation_result(input logic deriv,
                                                               input logic signed [DW-1:0] v);
        longint x;
        longint mag;
        longint y;
        longint r;
        longint lin;
        longint leak;
        x    = longint'(v);
        mag  = (x < 0) ? -x : x;
        lin  = longint'(cur_linear);
        leak = longint'(cur_leak);
        case (cur_kind)
            KIND_SIGMOID: begin
                y = curve_at(1'b0, mag);
                if (x < 0) begin
                    y = ONE_Q - y;
                end
                r = deriv ? round_frac(y * (ONE_Q - y)) : y;
            end
            KIND_STEP: begin
                r = deriv ? 0 : ((x > 0) ? ONE_Q : 0);
            end
            KIND_LINEAR: begin
                r = deriv ? lin : round_frac(x * lin);
            end
            KIND_TANH: begin
                y = curve_at(1'b1, mag);
                if (x < 0) begin
                    y = -y;
                end
                r = deriv ? ONE_Q - round_frac(y * y) : y;
            end
            KIND_RELU: begin
                if (deriv) begin
                    r = (x >= 0) ? ONE_Q : 0;
                end else begin
                    r = (x > 0) ? x : 0;
                end
            end
            KIND_LEAKY: begin
                if (deriv) begin
                    r = (x >= 0) ? ONE_Q : leak;
                end else begin
                    r = (x >= 0) ? x : round_frac(x * leak);
                end
            end
            default: begin
                r = x;
            end
        endcase
        if (r > (64'sd1 << (DW - 1)) - 1) begin
            r = (64'sd1 << (DW - 1)) - 1;
        end else if (r < -(64'sd1 << (DW - 1))) begin
            r = -(64'sd1 << (DW - 1));
        end
        return DW'(r);
    endfunction

    function automatic logic signed [DW-1:0] random_value();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 9))
                    0:       return 16'sh8000;
                    1:       return 16'sh8001;
                    2:       return -16'sd4096;
                    3:       return -16'sd1;
                    4:       return 16'sd0;
                    5:       return 16'sd1;
                    6:       return 16'sd4096;
                    7:       return 16'sh7fff;
                    8:       return 16'sd2048;
                    default: return -16'sd2048;
                endcase
            end
            1:       return DW'(int'($urandom_range(0, 16383)) - 8192);
            default: return DW'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 13'd4096;
            2:       return '1;
            default: return GAIN_W'($urandom_range(0, 8191));
        endcase
    endfunction

    function automatic void push_stim(input logic m, input logic signed [DW-1:0] v);
        t_stim s;
        s.mode  = m;
        s.value = v;
        pending_stim.insert(pending_stim.size(), s);
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        error_count++;
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << 2;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(input logic [KIND_W-1:0] k, input logic [GAIN_W-1:0] lin,
                                input logic [GAIN_W-1:0] leak);
        apb_write(REG_KIND, APB_DW'(k));
        apb_write(REG_LINEAR, APB_DW'(lin));
        apb_write(REG_LEAK, APB_DW'(leak));
        cur_kind   = k;
        cur_linear = lin;
        cur_leak   = leak;
    endtask

    // nothing queued, nothing in flight, then a drain margin
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_stim.size() != 0 || i_in_valid || predicted_outputs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // input driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predicted_outputs.insert(predicted_outputs.size(),
                                         activation_result(i_mode, i_value));
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the pending transfer
            end else if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_stim.size() != 0) begin
                next_stim  = pending_stim.pop_front();
                i_in_valid <= 1'b1;
                i_mode     <= next_stim.mode;
                i_value    <= next_stim.value;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_outputs.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing expected", o_result));
                end else begin
                    want = predicted_outputs.pop_front();
                    if (o_result !== want) begin
                        report_mismatch($sformatf("result got %0d expected %0d (kind %0d)",
                                                  o_result, want, cur_kind));
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(30, 200);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 3) != 0);
                2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (cycle_count % 3 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int                total;
        int                phase;
        int                n;
        logic [KIND_W-1:0] k;
        logic [GAIN_W-1:0] lin;
        logic [GAIN_W-1:0] leak;
        fill_curves();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: sigmoid at the range ends and around zero
        push_stim(1'b0, 16'sh8000);
        push_stim(1'b0, 16'sh7fff);
        push_stim(1'b1, 16'sd0);
        push_stim(1'b1, -16'sd1);
        push_stim(1'b0, 16'sd1);

        // each remaining kind, the unused code included
        for (int kk = KIND_STEP; kk <= KIND_UNKNOWN; kk++) begin
            wait_drained();
            apply_config(KIND_W'(kk), LINEAR_DEF, LEAK_DEF);
            push_stim(1'b0, 16'sh8000);
            push_stim(1'b1, 16'sd0);
            push_stim(1'b1, -16'sd1);
        end

        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS) begin
            wait_drained();
            lin  = random_gain();
            leak = random_gain();
            if (phase < 3) begin
                k   = KIND_LINEAR;
                lin = (phase == 0) ? 13'd0 : (phase == 1) ? 13'd4096 : 13'h1fff;
            end else if (phase < 6) begin
                k    = KIND_LEAKY;
                leak = (phase == 3) ? 13'd0 : (phase == 4) ? 13'd4096 : 13'h1fff;
            end else begin
                k = KIND_W'($urandom_range(0, 7));
            end
            apply_config(k, lin, leak);
            n = $urandom_range(30, 120);
            repeat (n) push_stim(1'($urandom_range(0, 1)), random_value());
            total += n;
            phase++;
        end

        wait_drained();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
